[rtl/mvfp_pkg.sv]
package mvfp_pkg;

  // Map geometry.
  localparam int MAX_MB_COLUMNS = 128;
  localparam int MAX_MB_ROWS    = 128;
  localparam int NUM_REFERENCES = 3;

  localparam int MAP_DEPTH = NUM_REFERENCES * MAX_MB_ROWS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int COL_IW    = $clog2(MAX_MB_COLUMNS);
  localparam int ROW_IW    = $clog2(MAX_MB_ROWS);
  localparam int IDX_W     = (COL_IW > ROW_IW) ? COL_IW : ROW_IW;
  localparam int ECOL_W    = $clog2(MAX_MB_COLUMNS + 1);
  localparam int EROW_W    = $clog2(MAX_MB_ROWS + 1);

  // Fixed field widths.
  localparam int GRID_W    = 8;
  localparam int CFG_IW    = 1;
  localparam int OUT_IDX_W = 7;
  localparam int PIX_W     = 15;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_GRID_COLUMNS = 1'b0;
  localparam logic [CFG_IW-1:0] REG_GRID_ROWS    = 1'b1;

  // Command codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_RECORD = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Block size codes.
  localparam logic [1:0] BSZ_4 = 2'd0;
  localparam logic [1:0] BSZ_8 = 2'd1;

  // Pixel to macroblock shifts.
  localparam int MB8_SHIFT  = 3;
  localparam int MB16_SHIFT = 4;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;
    logic load_origin;
    logic load_bounds;
    logic load_mask;
    logic row_next;
    logic rec_rd;
    logic rec_wr;
    logic q_rd;
    logic load_needed;
    logic sweep_wr;
    logic load_out;
  } mvfp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] command;
    logic       ref_ok;
    logic       row_last;
    logic       sweep_last;
  } mvfp_sts_t;

endpackage

[rtl/mvfp_ram.sv]
module mvfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/mvfp_ctrl.sv]
module mvfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output mvfp_pkg::mvfp_cmd_t cmd,
  input  mvfp_pkg::mvfp_sts_t sts
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_BOUNDS,
    ST_MASK,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_QCAP,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   from_item_r, from_item_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    from_item_nxt = from_item_r;
    cmd           = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = from_item_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          from_item_nxt = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.load_origin = 1'b1;
        case (sts.command)
          mvfp_pkg::CMD_CLEAR:  state_nxt = ST_CLEAR;
          mvfp_pkg::CMD_RECORD: state_nxt = ST_BOUNDS;
          mvfp_pkg::CMD_QUERY: begin
            cmd.q_rd  = 1'b1;
            state_nxt = ST_QCAP;
          end
          default:              state_nxt = ST_DONE;
        endcase
      end
      ST_BOUNDS: begin
        cmd.load_bounds = 1'b1;
        state_nxt       = ST_MASK;
      end
      ST_MASK: begin
        cmd.load_mask = 1'b1;
        state_nxt     = sts.ref_ok ? ST_ROW_RD : ST_DONE;
      end
      ST_ROW_RD: begin
        cmd.rec_rd = 1'b1;
        state_nxt  = ST_ROW_WR;
      end
      ST_ROW_WR: begin
        cmd.rec_wr = 1'b1;
        if (sts.row_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.row_next = 1'b1;
          state_nxt    = ST_ROW_RD;
        end
      end
      ST_QCAP: begin
        cmd.load_needed = 1'b1;
        state_nxt       = ST_DONE;
      end
      ST_DONE: begin
        // Load the output register once the previous result has gone.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
      from_item_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      from_item_r <= from_item_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second item taken while one is in work");

  a_wr_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sweep_wr && (cmd.rec_wr || cmd.rec_rd)))
    else $error("clearing pass overlaps a record access");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_ready) |=> state_r == ST_DONE)
    else $error("result overwrote a pending transfer");
`endif

endmodule

[rtl/mvfp_datapath.sv]
module mvfp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mvfp_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [mvfp_pkg::GRID_W-1:0]         cfg_data,
  input  logic [1:0]                          in_command,
  input  logic [1:0]                          in_ref_index,
  input  logic [8:0]                          in_blk_col,
  input  logic [8:0]                          in_blk_row,
  input  logic signed [12:0]                  in_mv_x,
  input  logic signed [12:0]                  in_mv_y,
  input  logic [1:0]                          in_block_size,
  input  logic                                in_mb_size,
  input  mvfp_pkg::mvfp_cmd_t                 cmd,
  output mvfp_pkg::mvfp_sts_t                 sts,
  output logic                                out_needed,
  output logic [mvfp_pkg::OUT_IDX_W-1:0]      out_first_row,
  output logic [mvfp_pkg::OUT_IDX_W-1:0]      out_last_row,
  output logic [mvfp_pkg::OUT_IDX_W-1:0]      out_first_col,
  output logic [mvfp_pkg::OUT_IDX_W-1:0]      out_last_col
);

  localparam int PW = mvfp_pkg::PIX_W;
  localparam int IW = mvfp_pkg::IDX_W;
  localparam int AW = mvfp_pkg::MAP_AW;
  localparam int MW = mvfp_pkg::MAX_MB_COLUMNS;
  localparam int OW = mvfp_pkg::OUT_IDX_W;

  // Pixel coordinate to clamped macroblock index.
  function automatic logic [IW-1:0] to_mb(logic signed [PW-1:0] pix, logic mb16,
                                          logic [PW-1:0] grid);
    logic [PW-1:0] m;
    logic [PW-1:0] lim;
    m   = mb16 ? ($unsigned(pix) >> mvfp_pkg::MB16_SHIFT)
               : ($unsigned(pix) >> mvfp_pkg::MB8_SHIFT);
    lim = grid - PW'(1);
    if (m > lim) begin
      m = lim;
    end
    if (pix < 0) begin
      to_mb = '0;
    end else begin
      to_mb = IW'(m);
    end
  endfunction

  // Configuration registers.
  logic [mvfp_pkg::GRID_W-1:0] grid_cols_r, grid_rows_r;
  logic [mvfp_pkg::ECOL_W-1:0] eff_cols;
  logic [mvfp_pkg::EROW_W-1:0] eff_rows;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= mvfp_pkg::GRID_W'(1);
      grid_rows_r <= mvfp_pkg::GRID_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == mvfp_pkg::REG_GRID_COLUMNS) begin
        grid_cols_r <= cfg_data;
      end
      if (cfg_index == mvfp_pkg::REG_GRID_ROWS) begin
        grid_rows_r <= cfg_data;
      end
    end
  end

  // Effective grid: zero counts as one, oversize saturates.
  always_comb begin
    if (grid_cols_r == '0) begin
      eff_cols = mvfp_pkg::ECOL_W'(1);
    end else if (32'(grid_cols_r) > mvfp_pkg::MAX_MB_COLUMNS) begin
      eff_cols = mvfp_pkg::ECOL_W'(mvfp_pkg::MAX_MB_COLUMNS);
    end else begin
      eff_cols = mvfp_pkg::ECOL_W'(grid_cols_r);
    end
    if (grid_rows_r == '0) begin
      eff_rows = mvfp_pkg::EROW_W'(1);
    end else if (32'(grid_rows_r) > mvfp_pkg::MAX_MB_ROWS) begin
      eff_rows = mvfp_pkg::EROW_W'(mvfp_pkg::MAX_MB_ROWS);
    end else begin
      eff_rows = mvfp_pkg::EROW_W'(grid_rows_r);
    end
  end

  // Item registers.
  logic [1:0]         cmd_code_r, ref_r, bsz_r;
  logic [8:0]         bcol_r, brow_r;
  logic signed [12:0] mvx_r, mvy_r;
  logic               mbs_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_code_r <= in_command;
      ref_r      <= in_ref_index;
      bcol_r     <= in_blk_col;
      brow_r     <= in_blk_row;
      mvx_r      <= in_mv_x;
      mvy_r      <= in_mv_y;
      bsz_r      <= in_block_size;
      mbs_r      <= in_mb_size;
    end
  end

  // Block edge in pixels and its shift.
  logic [2:0]           edge_sh;
  logic signed [PW-1:0] edge_px;

  always_comb begin
    case (bsz_r)
      mvfp_pkg::BSZ_4: edge_sh = 3'd2;
      mvfp_pkg::BSZ_8: edge_sh = 3'd3;
      default:         edge_sh = 3'd4;
    endcase
    edge_px = PW'(1) <<< edge_sh;
  end

  // Stage one: pixel origin of the prediction block.
  logic signed [PW-1:0] org_c_r, org_r_r;
  logic                 subpel_r;

  always_ff @(posedge clk) begin
    if (cmd.load_origin) begin
      org_c_r  <= $signed(PW'(bcol_r) << edge_sh) + PW'(mvx_r >>> 3);
      org_r_r  <= $signed(PW'(brow_r) << edge_sh) + PW'(mvy_r >>> 3);
      subpel_r <= (mvx_r[2:0] != 3'd0) || (mvy_r[2:0] != 3'd0);
    end
  end

  // Stage two: pixel span, then clamped macroblock bounds.
  logic signed [PW-1:0] lo_c, hi_c, lo_r, hi_r;
  logic [IW-1:0]        fc_r, lc_r, fr_r, lr_r;

  always_comb begin
    if (subpel_r) begin
      lo_c = org_c_r - PW'(2);
      hi_c = org_c_r + edge_px + PW'(3);
      lo_r = org_r_r - PW'(2);
      hi_r = org_r_r + edge_px + PW'(3);
    end else begin
      lo_c = org_c_r;
      hi_c = org_c_r + edge_px - PW'(1);
      lo_r = org_r_r;
      hi_r = org_r_r + edge_px - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bounds) begin
      fc_r <= to_mb(lo_c, mbs_r, PW'(eff_cols));
      lc_r <= to_mb(hi_c, mbs_r, PW'(eff_cols));
      fr_r <= to_mb(lo_r, mbs_r, PW'(eff_rows));
      lr_r <= to_mb(hi_r, mbs_r, PW'(eff_rows));
    end
  end

  // Stage three: column mask and row walk.
  logic [MW-1:0] mask_r;
  logic [IW-1:0] row_r;

  always_ff @(posedge clk) begin
    if (cmd.load_mask) begin
      mask_r <= ({MW{1'b1}} << fc_r) & ({MW{1'b1}} >> (MW - 1 - int'(lc_r)));
      row_r  <= fr_r;
    end else if (cmd.row_next) begin
      row_r <= row_r + IW'(1);
    end
  end

  // Clearing pass address.
  logic [AW-1:0] sweep_r;
  logic          sweep_last;

  assign sweep_last = (sweep_r == AW'(mvfp_pkg::MAP_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_r <= sweep_last ? '0 : sweep_r + AW'(1);
    end
  end

  // Map memory: one row word per reference and macroblock row.
  logic [AW-1:0] base_addr, rec_addr, q_addr;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata, mem_rdata;

  assign base_addr = AW'(ref_r) * AW'(mvfp_pkg::MAX_MB_ROWS);
  assign rec_addr  = base_addr + AW'(row_r);
  assign q_addr    = base_addr + AW'(brow_r[mvfp_pkg::ROW_IW-1:0]);
  assign mem_we    = cmd.sweep_wr || cmd.rec_wr;
  assign mem_waddr = cmd.sweep_wr ? sweep_r : rec_addr;
  assign mem_wdata = cmd.sweep_wr ? '0 : (mem_rdata | mask_r);
  assign mem_re    = cmd.rec_rd || cmd.q_rd;
  assign mem_raddr = cmd.q_rd ? q_addr : rec_addr;

  mvfp_ram #(
    .WIDTH(MW),
    .DEPTH(mvfp_pkg::MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Query answer, guarded against positions outside the grid.
  logic ref_ok, q_ok, needed_r;

  assign ref_ok = (32'(ref_r) < mvfp_pkg::NUM_REFERENCES);
  assign q_ok   = ref_ok && (32'(bcol_r) < 32'(eff_cols)) && (32'(brow_r) < 32'(eff_rows));

  always_ff @(posedge clk) begin
    if (cmd.load_needed) begin
      needed_r <= q_ok && mem_rdata[bcol_r[mvfp_pkg::COL_IW-1:0]];
    end
  end

  // Output register.
  logic          out_needed_r;
  logic [OW-1:0] out_fr_r, out_lr_r, out_fc_r, out_lc_r;
  logic          is_rec;

  assign is_rec = (cmd_code_r == mvfp_pkg::CMD_RECORD);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_needed_r <= (cmd_code_r == mvfp_pkg::CMD_QUERY) && needed_r;
      out_fr_r     <= is_rec ? OW'(fr_r) : '0;
      out_lr_r     <= is_rec ? OW'(lr_r) : '0;
      out_fc_r     <= is_rec ? OW'(fc_r) : '0;
      out_lc_r     <= is_rec ? OW'(lc_r) : '0;
    end
  end

  assign out_needed    = out_needed_r;
  assign out_first_row = out_fr_r;
  assign out_last_row  = out_lr_r;
  assign out_first_col = out_fc_r;
  assign out_last_col  = out_lc_r;

  assign sts.command    = cmd_code_r;
  assign sts.ref_ok     = ref_ok;
  assign sts.row_last   = (row_r == lr_r);
  assign sts.sweep_last = sweep_last;

`ifndef NO_ASSERTIONS
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && is_rec) |=> (out_fr_r <= out_lr_r) && (out_fc_r <= out_lc_r))
    else $error("record bounds out of order");

  a_row_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_wr |-> (row_r >= fr_r) && (row_r <= lr_r))
    else $error("row write outside the marked span");
`endif

endmodule

[rtl/mv_reference_footprint_marker.sv]
// Marks which macroblocks of the last, golden and altref frames a block's
// motion-compensated prediction reads, one 128-bit row word per reference
// and macroblock row in a 384-word map memory. Every input transfer yields
// exactly one result transfer. Items are handled one at a time, and the next
// item is taken while a result still waits on the output. A query reads one
// map row word; a record reads and then writes back each marked macroblock
// row of the map (a read-modify-write through its write port and registered
// read port), and marks nothing when the reference index is unused. A clear
// item, and reset, sweep all 384 row words at one word a cycle; during the
// sweep after reset the input stays not ready.
// The grid registers may be written whenever the block is idle.
module mv_reference_footprint_marker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mvfp_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [mvfp_pkg::GRID_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_command,
  input  logic [1:0]                     in_ref_index,
  input  logic [8:0]                     in_blk_col,
  input  logic [8:0]                     in_blk_row,
  input  logic signed [12:0]             in_mv_x,
  input  logic signed [12:0]             in_mv_y,
  input  logic [1:0]                     in_block_size,
  input  logic                           in_mb_size,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_needed,
  output logic [mvfp_pkg::OUT_IDX_W-1:0] out_first_row,
  output logic [mvfp_pkg::OUT_IDX_W-1:0] out_last_row,
  output logic [mvfp_pkg::OUT_IDX_W-1:0] out_first_col,
  output logic [mvfp_pkg::OUT_IDX_W-1:0] out_last_col
);

  mvfp_pkg::mvfp_cmd_t cmd;
  mvfp_pkg::mvfp_sts_t sts;

  // Sequencer.
  mvfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Geometry, map memory and result register.
  mvfp_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_command   (in_command),
    .in_ref_index (in_ref_index),
    .in_blk_col   (in_blk_col),
    .in_blk_row   (in_blk_row),
    .in_mv_x      (in_mv_x),
    .in_mv_y      (in_mv_y),
    .in_block_size(in_block_size),
    .in_mb_size   (in_mb_size),
    .cmd          (cmd),
    .sts          (sts),
    .out_needed   (out_needed),
    .out_first_row(out_first_row),
    .out_last_row (out_last_row),
    .out_first_col(out_first_col),
    .out_last_col (out_last_col)
  );

endmodule

[test/mvfp_footprint_checker.sv]
// Watches both channels and the grid register writes of the footprint marker,
// keeps its own copy of the three reference bitmaps and predicts every
// result. Each result transfer is compared field by field against the oldest
// prediction.
module mvfp_footprint_checker
  import mvfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [GRID_W-1:0]     cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [1:0]            in_ref_index,
  input  logic [8:0]            in_blk_col,
  input  logic [8:0]            in_blk_row,
  input  logic signed [12:0]    in_mv_x,
  input  logic signed [12:0]    in_mv_y,
  input  logic [1:0]            in_block_size,
  input  logic                  in_mb_size,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_needed,
  input  logic [OUT_IDX_W-1:0]  out_first_row,
  input  logic [OUT_IDX_W-1:0]  out_last_row,
  input  logic [OUT_IDX_W-1:0]  out_first_col,
  input  logic [OUT_IDX_W-1:0]  out_last_col,
  output int                    n_errors,
  output int                    n_expected
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0]         command;
    logic [1:0]         ref_index;
    logic [8:0]         blk_col;
    logic [8:0]         blk_row;
    logic signed [12:0] mv_x;
    logic signed [12:0] mv_y;
    logic [1:0]         block_size;
    logic               mb_size;
  } fp_item_t;

  typedef struct {
    logic                 needed;
    logic [OUT_IDX_W-1:0] first_row;
    logic [OUT_IDX_W-1:0] last_row;
    logic [OUT_IDX_W-1:0] first_col;
    logic [OUT_IDX_W-1:0] last_col;
  } fp_result_t;

  // Shadow copy of the bitmaps, one row word per reference and macroblock row.
  bit [MAX_MB_COLUMNS-1:0] ref_map [NUM_REFERENCES][MAX_MB_ROWS];
  logic [GRID_W-1:0]       grid_cols_reg = 8'd1;
  logic [GRID_W-1:0]       grid_rows_reg = 8'd1;
  fp_result_t              bounds_q [$];
  fp_item_t                seen_item;
  fp_result_t              want;
  fp_result_t              got;

  initial begin
    n_errors   = 0;
    n_expected = 0;
  end

  function automatic void wipe_maps();
    for (int g = 0; g < NUM_REFERENCES; g++) begin
      for (int r = 0; r < MAX_MB_ROWS; r++) begin
        ref_map[g][r] = '0;
      end
    end
  endfunction

  // A zero register counts as one, anything above the map size saturates.
  function automatic int clamp_grid(input logic [GRID_W-1:0] reg_val, input int max_val);
    if (reg_val == '0) return 1;
    if (int'(reg_val) > max_val) return max_val;
    return int'(reg_val);
  endfunction

  // Pixel coordinate to macroblock index, clamped into the grid.
  function automatic int pix_to_mb(input int pix, input int shift_b, input int grid);
    int m;
    if (pix < 0) return 0;
    m = pix >>> shift_b;
    if (m > grid - 1) m = grid - 1;
    return m;
  endfunction

  // Applies one item to the shadow maps and returns the result it must produce.
  function automatic fp_result_t predict_footprint(input fp_item_t it);
    fp_result_t res;
    int cols, rows, span, shift_b, mvx, mvy, px_c, px_r;
    int lo_c, hi_c, lo_r, hi_r, fr, lr, fc, lc;
    res.needed    = 1'b0;
    res.first_row = '0;
    res.last_row  = '0;
    res.first_col = '0;
    res.last_col  = '0;
    cols = clamp_grid(grid_cols_reg, MAX_MB_COLUMNS);
    rows = clamp_grid(grid_rows_reg, MAX_MB_ROWS);
    case (it.command)
      CMD_CLEAR: begin
        wipe_maps();
      end
      CMD_RECORD: begin
        case (it.block_size)
          BSZ_4:   span = 4;
          BSZ_8:   span = 8;
          default: span = 16;
        endcase
        shift_b = it.mb_size ? MB16_SHIFT : MB8_SHIFT;
        mvx = it.mv_x;
        mvy = it.mv_y;
        // Integer part of the vector rounds toward minus infinity.
        px_c = int'(it.blk_col) * span + (mvx >>> 3);
        px_r = int'(it.blk_row) * span + (mvy >>> 3);
        if (it.mv_x[2:0] == 3'd0 && it.mv_y[2:0] == 3'd0) begin
          lo_c = px_c;
          hi_c = px_c + span - 1;
          lo_r = px_r;
          hi_r = px_r + span - 1;
        end else begin
          // Sub-pel vectors need the interpolation filter taps around the block.
          lo_c = px_c - 2;
          hi_c = px_c + span + 3;
          lo_r = px_r - 2;
          hi_r = px_r + span + 3;
        end
        fc = pix_to_mb(lo_c, shift_b, cols);
        lc = pix_to_mb(hi_c, shift_b, cols);
        fr = pix_to_mb(lo_r, shift_b, rows);
        lr = pix_to_mb(hi_r, shift_b, rows);
        if (it.ref_index < NUM_REFERENCES) begin
          for (int r = fr; r <= lr; r++) begin
            for (int c = fc; c <= lc; c++) begin
              ref_map[it.ref_index][r][c] = 1'b1;
            end
          end
        end
        res.first_row = OUT_IDX_W'(fr);
        res.last_row  = OUT_IDX_W'(lr);
        res.first_col = OUT_IDX_W'(fc);
        res.last_col  = OUT_IDX_W'(lc);
      end
      CMD_QUERY: begin
        if (it.ref_index < NUM_REFERENCES && int'(it.blk_col) < cols &&
            int'(it.blk_row) < rows) begin
          res.needed = ref_map[it.ref_index][it.blk_row][it.blk_col];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_maps();
      grid_cols_reg = 8'd1;
      grid_rows_reg = 8'd1;
      bounds_q.delete();
      n_expected = 0;
    end else begin
      // Result transfer: check against the oldest prediction.
      if (out_valid && out_ready) begin
        got.needed    = out_needed;
        got.first_row = out_first_row;
        got.last_row  = out_last_row;
        got.first_col = out_first_col;
        got.last_col  = out_last_col;
        if (bounds_q.size() == 0) begin
          if (n_errors < MAX_REPORTS) begin
            $display("ERROR: result transfer with nothing expected:");
            $display("       actual   needed=%0d rows %0d..%0d cols %0d..%0d",
                     got.needed, got.first_row, got.last_row, got.first_col, got.last_col);
          end
          n_errors++;
        end else begin
          want = bounds_q.pop_front();
          if (got.needed !== want.needed || got.first_row !== want.first_row ||
              got.last_row !== want.last_row || got.first_col !== want.first_col ||
              got.last_col !== want.last_col) begin
            if (n_errors < MAX_REPORTS) begin
              $display("ERROR: expected needed=%0d rows %0d..%0d cols %0d..%0d", want.needed,
                       want.first_row, want.last_row, want.first_col, want.last_col);
              $display("       actual   needed=%0d rows %0d..%0d cols %0d..%0d", got.needed,
                       got.first_row, got.last_row, got.first_col, got.last_col);
            end
            n_errors++;
          end
        end
      end
      // Input transfer: predict its result.
      if (in_valid && in_ready) begin
        seen_item.command    = in_command;
        seen_item.ref_index  = in_ref_index;
        seen_item.blk_col    = in_blk_col;
        seen_item.blk_row    = in_blk_row;
        seen_item.mv_x       = in_mv_x;
        seen_item.mv_y       = in_mv_y;
        seen_item.block_size = in_block_size;
        seen_item.mb_size    = in_mb_size;
        bounds_q.push_back(predict_footprint(seen_item));
      end
      // Grid register writes.
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_COLUMNS: grid_cols_reg = cfg_data;
          REG_GRID_ROWS:    grid_rows_reg = cfg_data;
          default: begin
          end
        endcase
      end
      n_expected = bounds_q.size();
    end
  end

endmodule

[test/tb_mv_reference_footprint_marker.sv]
// Stimulus and verdict for the reference footprint marker. Prediction and
// checking live in the checker instantiated next to the block.
module tb_mv_reference_footprint_marker;
  timeunit 1ns;
  timeprecision 1ps;
  import mvfp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REF_LAST   = 2'd0;
  localparam logic [1:0] REF_GOLDEN = 2'd1;
  localparam logic [1:0] REF_ALTREF = 2'd2;
  localparam logic [1:0] REF_UNUSED = 2'd3;
  localparam logic [1:0] BSZ_16     = 2'd2;
  localparam logic [1:0] BSZ_UNUSED = 2'd3;

  localparam int RESET_CYCLES    = 12;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 75;

  typedef struct {
    logic [1:0]         command;
    logic [1:0]         ref_index;
    logic [8:0]         blk_col;
    logic [8:0]         blk_row;
    logic signed [12:0] mv_x;
    logic signed [12:0] mv_y;
    logic [1:0]         block_size;
    logic               mb_size;
  } mv_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IW-1:0]     cfg_index = REG_GRID_COLUMNS;
  logic [GRID_W-1:0]     cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_command = CMD_CLEAR;
  logic [1:0]            in_ref_index = REF_LAST;
  logic [8:0]            in_blk_col = '0;
  logic [8:0]            in_blk_row = '0;
  logic signed [12:0]    in_mv_x = '0;
  logic signed [12:0]    in_mv_y = '0;
  logic [1:0]            in_block_size = BSZ_4;
  logic                  in_mb_size = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_needed;
  logic [OUT_IDX_W-1:0]  out_first_row;
  logic [OUT_IDX_W-1:0]  out_last_row;
  logic [OUT_IDX_W-1:0]  out_first_col;
  logic [OUT_IDX_W-1:0]  out_last_col;

  int n_errors;
  int n_expected;
  int sender_pct = 0;
  int receiver_pct = 0;
  bit hold_req = 1'b0;
  int grid_cols_eff = 1;
  int grid_rows_eff = 1;
  int idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mv_reference_footprint_marker i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_ref_index    (in_ref_index),
    .in_blk_col      (in_blk_col),
    .in_blk_row      (in_blk_row),
    .in_mv_x         (in_mv_x),
    .in_mv_y         (in_mv_y),
    .in_block_size   (in_block_size),
    .in_mb_size      (in_mb_size),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_needed      (out_needed),
    .out_first_row   (out_first_row),
    .out_last_row    (out_last_row),
    .out_first_col   (out_first_col),
    .out_last_col    (out_last_col)
  );

  mvfp_footprint_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_ref_index    (in_ref_index),
    .in_blk_col      (in_blk_col),
    .in_blk_row      (in_blk_row),
    .in_mv_x         (in_mv_x),
    .in_mv_y         (in_mv_y),
    .in_block_size   (in_block_size),
    .in_mb_size      (in_mb_size),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_needed      (out_needed),
    .out_first_row   (out_first_row),
    .out_last_row    (out_last_row),
    .out_first_col   (out_first_col),
    .out_last_col    (out_last_col),
    .n_errors        (n_errors),
    .n_expected      (n_expected)
  );

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= receiver_pct);
    end
  end

  // Offers one item, after a random gap, and returns at the falling edge
  // after its transfer with valid still high.
  task automatic send_item(input mv_item_t it);
    while ($urandom_range(99) < sender_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command    = it.command;
    in_ref_index  = it.ref_index;
    in_blk_col    = it.blk_col;
    in_blk_row    = it.blk_row;
    in_mv_x       = it.mv_x;
    in_mv_y       = it.mv_y;
    in_block_size = it.block_size;
    in_mb_size    = it.mb_size;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [1:0] cmd, input logic [1:0] ref_sel,
                             input int col, input int row, input int mvx, input int mvy,
                             input logic [1:0] bsz, input logic mb);
    mv_item_t it;
    it.command    = cmd;
    it.ref_index  = ref_sel;
    it.blk_col    = 9'(col);
    it.blk_row    = 9'(row);
    it.mv_x       = 13'(mvx);
    it.mv_y       = 13'(mvy);
    it.block_size = bsz;
    it.mb_size    = mb;
    send_item(it);
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (n_expected != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_grid(input logic [GRID_W-1:0] cols, input logic [GRID_W-1:0] rows);
    cfg_we    = 1'b1;
    cfg_index = REG_GRID_COLUMNS;
    cfg_data  = cols;
    @(negedge clk);
    cfg_index = REG_GRID_ROWS;
    cfg_data  = rows;
    @(negedge clk);
    cfg_we = 1'b0;
    grid_cols_eff = (cols == 0) ? 1 : (cols > MAX_MB_COLUMNS) ? MAX_MB_COLUMNS : int'(cols);
    grid_rows_eff = (rows == 0) ? 1 : (rows > MAX_MB_ROWS) ? MAX_MB_ROWS : int'(rows);
  endtask

  // Mostly records and queries aimed at the grid, often at its top left
  // corner so that queries hit marked macroblocks; some items are pure noise.
  function automatic mv_item_t random_item(input int cols, input int rows);
    mv_item_t it;
    int pick, span, mb_px, focus_c, focus_r, c_hi, r_hi, mvx, mvy;
    pick = $urandom_range(99);
    if (pick < 2) it.command = CMD_CLEAR;
    else if (pick < 5) it.command = CMD_UNUSED;
    else if (pick < 52) it.command = CMD_RECORD;
    else it.command = CMD_QUERY;
    it.ref_index  = ($urandom_range(19) == 0) ? REF_UNUSED : 2'($urandom_range(2));
    it.block_size = 2'($urandom_range(3));
    it.mb_size    = 1'($urandom_range(1));
    it.mv_x       = 13'($urandom);
    it.mv_y       = 13'($urandom);
    it.blk_col    = 9'($urandom);
    it.blk_row    = 9'($urandom);
    if ($urandom_range(9) == 0) return it;
    focus_c = ($urandom_range(1) == 1 || cols < 6) ? cols : 6;
    focus_r = ($urandom_range(1) == 1 || rows < 6) ? rows : 6;
    if (it.command == CMD_QUERY) begin
      it.blk_col = 9'($urandom_range(focus_c));
      it.blk_row = 9'($urandom_range(focus_r));
    end else begin
      case (it.block_size)
        BSZ_4:   span = 4;
        BSZ_8:   span = 8;
        default: span = 16;
      endcase
      mb_px = it.mb_size ? 16 : 8;
      c_hi = focus_c * mb_px / span + 1;
      r_hi = focus_r * mb_px / span + 1;
      if (c_hi > 511) c_hi = 511;
      if (r_hi > 511) r_hi = 511;
      it.blk_col = 9'($urandom_range(c_hi));
      it.blk_row = 9'($urandom_range(r_hi));
      mvx = int'($urandom_range(255)) - 128;
      mvy = int'($urandom_range(255)) - 128;
      if ($urandom_range(1) == 1) begin
        mvx = mvx & ~7;
        mvy = mvy & ~7;
      end
      it.mv_x = 13'(mvx);
      it.mv_y = 13'(mvy);
    end
    return it;
  endfunction

  initial begin
    int phase_cols;
    int phase_rows;
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    // The maps are swept after reset; wait until the block takes input.
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);

    // Directed part on a 20 x 12 grid, no idling.
    write_grid(8'd20, 8'd12);
    send_fields(CMD_RECORD, REF_LAST, 0, 0, 0, 0, BSZ_4, 1'b1);
    send_fields(CMD_RECORD, REF_GOLDEN, 1, 1, -4096, -4096, BSZ_8, 1'b0);
    send_fields(CMD_RECORD, REF_ALTREF, 511, 511, 4095, 4095, BSZ_16, 1'b0);
    // Sub-pel in one axis only widens both axes.
    send_fields(CMD_RECORD, REF_LAST, 5, 3, 3, 0, BSZ_8, 1'b1);
    send_fields(CMD_RECORD, REF_GOLDEN, 2, 6, 0, -5, BSZ_16, 1'b0);
    send_fields(CMD_RECORD, REF_ALTREF, 4, 4, 16, -24, BSZ_UNUSED, 1'b1);
    send_fields(CMD_RECORD, REF_UNUSED, 2, 2, 9, 9, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_LAST, 0, 0, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_ALTREF, 19, 11, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_GOLDEN, 0, 0, 0, 0, BSZ_4, 1'b0);
    // Queries at and beyond the grid edge, and with the unused map index.
    send_fields(CMD_QUERY, REF_LAST, 20, 0, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_GOLDEN, 0, 12, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_ALTREF, 511, 511, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_UNUSED, 2, 2, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_UNUSED, REF_ALTREF, 511, 511, -1, 4095, BSZ_UNUSED, 1'b1);
    send_fields(CMD_QUERY, REF_LAST, 0, 0, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_CLEAR, REF_LAST, 0, 0, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_LAST, 0, 0, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_ALTREF, 19, 11, 0, 0, BSZ_4, 1'b0);
    send_fields(CMD_RECORD, REF_LAST, 7, 7, -1, 1, BSZ_4, 1'b0);
    send_fields(CMD_QUERY, REF_LAST, 3, 3, 0, 0, BSZ_4, 1'b0);
    wait_drained();

    // Random phases, each with its own grid and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin phase_cols = 40;  phase_rows = 30;  sender_pct = 0;  receiver_pct = 0;  end
        1: begin phase_cols = 255; phase_rows = 255; sender_pct = 88; receiver_pct = 0;  end
        2: begin phase_cols = 0;   phase_rows = 0;   sender_pct = 0;  receiver_pct = 88; end
        3: begin phase_cols = 128; phase_rows = 128; sender_pct = 8;  receiver_pct = 8;  end
        4: begin phase_cols = 1;   phase_rows = 128; sender_pct = 0;  receiver_pct = 0;  end
        5: begin phase_cols = 128; phase_rows = 1;   sender_pct = 88; receiver_pct = 0;  end
        6: begin
          phase_cols = $urandom_range(1, 128);
          phase_rows = $urandom_range(1, 128);
          sender_pct = 0;
          receiver_pct = 88;
        end
        default: begin phase_cols = 17; phase_rows = 9; sender_pct = 8; receiver_pct = 8; end
      endcase
      write_grid(GRID_W'(phase_cols), GRID_W'(phase_rows));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Back-pressure: the result side holds off while items keep coming.
        if (p == 0 && k == 20) hold_req = 1'b1;
        // Sender pause until the block has delivered everything.
        if (p == 0 && k == 50) wait_drained();
        send_item(random_item(grid_cols_eff, grid_rows_eff));
      end
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mvfp_pkg.sv
rtl/mvfp_ram.sv
rtl/mvfp_ctrl.sv
rtl/mvfp_datapath.sv
rtl/mv_reference_footprint_marker.sv
test/mvfp_footprint_checker.sv
test/tb_mv_reference_footprint_marker.sv
